// ===== sv/scpwm_pkg.sv =====
package scpwm_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_PRESCALE = 1'b0,
        CFG_SLEEP    = 1'b1
    } cfg_index_t;

    localparam logic [7:0] MODE_ADDR      = 8'h00;
    localparam logic [7:0] PRESCALE_ADDR  = 8'hFE;
    localparam logic [7:0] BASE_ADDR      = 8'h06;
    localparam int         SLEEP_BIT      = 4;
    localparam logic [7:0] MIN_PRESCALE   = 8'd3;
    localparam logic [7:0] PRESCALE_RESET = 8'd30;
    localparam int         LEVEL_BITS     = 16;

    localparam logic [1:0] SEL_ON_LOW   = 2'd0;
    localparam logic [1:0] SEL_ON_HIGH  = 2'd1;
    localparam logic [1:0] SEL_OFF_LOW  = 2'd2;
    localparam logic [1:0] SEL_OFF_HIGH = 2'd3;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] offset;
        logic [7:0] wdata;
    } bank_req_t;

endpackage

// ===== sv/scpwm_timebase.sv =====
module scpwm_timebase import scpwm_pkg::*; #(
    parameter int COUNT_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic [7:0]            prescale,
    output logic [COUNT_BITS-1:0] period_next
);

    logic [7:0]            presc_cnt_reg;
    logic [7:0]            presc_cnt_next;
    logic [COUNT_BITS-1:0] period_reg;
    logic [7:0]            eff_prescale;

    always_comb begin
        eff_prescale   = (prescale < MIN_PRESCALE) ? MIN_PRESCALE : prescale;
        presc_cnt_next = presc_cnt_reg;
        period_next    = period_reg;
        if (tick_en) begin
            if (presc_cnt_reg >= eff_prescale) begin
                presc_cnt_next = 8'd0;
                period_next    = period_reg + COUNT_BITS'(1);
            end else begin
                presc_cnt_next = presc_cnt_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presc_cnt_reg <= 8'd0;
            period_reg    <= '0;
        end else begin
            presc_cnt_reg <= presc_cnt_next;
            period_reg    <= period_next;
        end
    end

endmodule

// ===== sv/scpwm_bank.sv =====
module scpwm_bank import scpwm_pkg::*; #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bank_req_t             req,
    input  logic [COUNT_BITS-1:0] period_next,
    output logic [7:0]            rd_byte,
    output logic [LEVEL_BITS-1:0] levels_next
);

    logic [COUNT_BITS-1:0] on_reg  [CHANNELS];
    logic [COUNT_BITS-1:0] off_reg [CHANNELS];
    logic [COUNT_BITS-1:0] on_next [CHANNELS];
    logic [COUNT_BITS-1:0] off_next[CHANNELS];

    always_comb begin
        logic [15:0] on_wide;
        logic [15:0] off_wide;
        for (int i = 0; i < CHANNELS; i++) begin
            on_wide  = 16'(on_reg[i]);
            off_wide = 16'(off_reg[i]);
            if (req.wr_en && (req.offset[7:2] == 6'(i))) begin
                case (req.offset[1:0])
                    SEL_ON_LOW:   on_wide[7:0]   = req.wdata;
                    SEL_ON_HIGH:  on_wide[15:8]  = req.wdata;
                    SEL_OFF_LOW:  off_wide[7:0]  = req.wdata;
                    SEL_OFF_HIGH: off_wide[15:8] = req.wdata;
                    default:      on_wide        = 16'(on_reg[i]);
                endcase
            end
            on_next[i]  = on_wide[COUNT_BITS-1:0];
            off_next[i] = off_wide[COUNT_BITS-1:0];
        end
    end

    always_comb begin
        levels_next = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (on_next[i] == off_next[i]) begin
                levels_next[i] = 1'b0;
            end else if (on_next[i] < off_next[i]) begin
                levels_next[i] = (period_next >= on_next[i]) && (period_next < off_next[i]);
            end else begin
                levels_next[i] = (period_next >= on_next[i]) || (period_next < off_next[i]);
            end
        end
    end

    always_comb begin
        logic [15:0] on_rd;
        logic [15:0] off_rd;
        rd_byte = 8'd0;
        for (int i = 0; i < CHANNELS; i++) begin
            on_rd  = 16'(on_reg[i]);
            off_rd = 16'(off_reg[i]);
            if (req.offset[7:2] == 6'(i)) begin
                case (req.offset[1:0])
                    SEL_ON_LOW:   rd_byte = on_rd[7:0];
                    SEL_ON_HIGH:  rd_byte = on_rd[15:8];
                    SEL_OFF_LOW:  rd_byte = off_rd[7:0];
                    SEL_OFF_HIGH: rd_byte = off_rd[15:8];
                    default:      rd_byte = 8'd0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                on_reg[i]  <= '0;
                off_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                on_reg[i]  <= on_next[i];
                off_reg[i] <= off_next[i];
            end
        end
    end

endmodule

// ===== sv/sixteen_channel_pwm_controller.sv =====
// Sixteen-channel PWM controller with a byte register map. Each request on the
// slave stream is a register write, a register read or one oscillator tick, and
// each produces exactly one response holding the read byte, the channel levels
// after the request and an access error flag. The block takes one request per
// clock while the master side keeps tready high: a request waits in the input
// register, its register update, counter step and sixteen window compares are
// done combinationally from it, and the response is loaded into the output
// register, which presents it; while the master side stalls, the request
// stays there. The prescale and sleep registers may also be set
// through the configuration port while no request is in flight.
module sixteen_channel_pwm_controller import scpwm_pkg::*; #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_addr[7:0], write_data[15:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], pwm_levels[23:8], access_error[24]
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam logic [8:0] CHAN_END = 9'(int'(BASE_ADDR) + 4 * CHANNELS);

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_addr_reg;
    logic [7:0]  in_data_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_rdata_reg;
    logic [LEVEL_BITS-1:0] out_levels_reg;
    logic        out_err_reg;

    logic        sleep_reg;
    logic        sleep_next;
    logic [7:0]  prescale_reg;
    logic [7:0]  prescale_next;

    logic        proc_fire;
    logic        is_chan;
    logic        is_mode;
    logic        is_presc;
    logic        tick_en;
    logic [7:0]  rdata;
    logic        err;
    logic [7:0]  bank_rd;
    logic [LEVEL_BITS-1:0] levels_next;
    logic [COUNT_BITS-1:0] period_next;
    bank_req_t   bank_req;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    assign is_chan  = (in_addr_reg >= BASE_ADDR) && ({1'b0, in_addr_reg} < CHAN_END);
    assign is_mode  = (in_addr_reg == MODE_ADDR);
    assign is_presc = (in_addr_reg == PRESCALE_ADDR);

    always_comb begin
        bank_req.wr_en  = 1'b0;
        bank_req.offset = in_addr_reg - BASE_ADDR;
        bank_req.wdata  = in_data_reg;
        sleep_next      = sleep_reg;
        prescale_next   = prescale_reg;
        tick_en         = 1'b0;
        rdata           = 8'd0;
        err             = 1'b0;
        if (proc_fire) begin
            case (in_cmd_reg)
                CMD_WRITE: begin
                    if (is_chan) begin
                        bank_req.wr_en = 1'b1;
                    end else if (is_mode) begin
                        sleep_next = in_data_reg[SLEEP_BIT];
                    end else if (is_presc) begin
                        if (sleep_reg) begin
                            prescale_next = in_data_reg;
                        end
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (is_chan) begin
                        rdata = bank_rd;
                    end else if (is_mode) begin
                        rdata = 8'(sleep_reg) << SLEEP_BIT;
                    end else if (is_presc) begin
                        rdata = prescale_reg;
                    end else begin
                        err = 1'b1;
                    end
                end
                CMD_TICK: begin
                    tick_en = !sleep_reg;
                end
                default: begin
                    tick_en = 1'b0;
                end
            endcase
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PRESCALE: prescale_next = cfg_wdata;
                CFG_SLEEP:    sleep_next    = cfg_wdata[0];
                default:      sleep_next    = sleep_reg;
            endcase
        end
    end

    assign out_valid_next = proc_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    scpwm_timebase #(
        .COUNT_BITS (COUNT_BITS)
    ) u_timebase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick_en),
        .prescale    (prescale_reg),
        .period_next (period_next)
    );

    scpwm_bank #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (bank_req),
        .period_next (period_next),
        .rd_byte     (bank_rd),
        .levels_next (levels_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sleep_reg     <= 1'b1;
            prescale_reg  <= PRESCALE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            sleep_reg     <= sleep_next;
            prescale_reg  <= prescale_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
        end
        if (proc_fire) begin
            out_rdata_reg  <= rdata;
            out_levels_reg <= levels_next;
            out_err_reg    <= err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_err_reg, out_levels_reg, out_rdata_reg};

endmodule

// ===== dv/tb_sixteen_channel_pwm_controller.sv =====
module tb_sixteen_channel_pwm_controller import scpwm_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] levels;
        logic        err;
    } pwm_resp_t;

    // Tracks the register map, prescaler and period counter, and holds the
    // responses still owed by the block in request order.
    class pwm_scoreboard;
        logic [7:0]  count_bytes [64];
        logic [7:0]  prescale;
        logic        sleep;
        logic [7:0]  tick_count;
        logic [11:0] period;
        pwm_resp_t   expected_resp [$];
        int          errors;

        function new();
            foreach (count_bytes[i]) count_bytes[i] = 8'h00;
            prescale   = PRESCALE_RESET;
            sleep      = 1'b1;
            tick_count = 8'd0;
            period     = 12'd0;
            errors     = 0;
        endfunction

        function void cfg_write(cfg_index_t idx, logic [7:0] v);
            if (idx == CFG_PRESCALE) begin
                prescale = v;
            end else begin
                sleep = v[0];
            end
        endfunction

        function logic [15:0] channel_levels();
            logic [15:0] lv;
            logic [11:0] on_cnt;
            logic [11:0] off_cnt;
            lv = '0;
            for (int n = 0; n < 16; n++) begin
                on_cnt  = {count_bytes[4*n+1][3:0], count_bytes[4*n]};
                off_cnt = {count_bytes[4*n+3][3:0], count_bytes[4*n+2]};
                if (on_cnt < off_cnt) begin
                    lv[n] = (period >= on_cnt) && (period < off_cnt);
                end else if (on_cnt > off_cnt) begin
                    lv[n] = (period >= on_cnt) || (period < off_cnt);
                end
            end
            return lv;
        endfunction

        function void note_request(logic [1:0] c, logic [7:0] a, logic [7:0] d);
            pwm_resp_t  r;
            logic [7:0] eff;
            int         ai;
            int         idx;
            bit         mapped;
            r      = '0;
            ai     = a;
            idx    = ai - BASE_ADDR;
            mapped = (ai >= BASE_ADDR) && (ai < BASE_ADDR + 64);
            case (c)
                CMD_WRITE: begin
                    if (mapped) begin
                        count_bytes[idx] = (idx % 2 == 1) ? (d & 8'h0F) : d;
                    end else if (a == MODE_ADDR) begin
                        sleep = d[SLEEP_BIT];
                    end else if (a == PRESCALE_ADDR) begin
                        if (sleep) prescale = d;
                    end else begin
                        r.err = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (mapped) begin
                        r.read_data = count_bytes[idx];
                    end else if (a == MODE_ADDR) begin
                        r.read_data = 8'(sleep) << SLEEP_BIT;
                    end else if (a == PRESCALE_ADDR) begin
                        r.read_data = prescale;
                    end else begin
                        r.err = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (!sleep) begin
                        eff = (prescale < MIN_PRESCALE) ? MIN_PRESCALE : prescale;
                        if (tick_count >= eff) begin
                            tick_count = 8'd0;
                            period     = period + 12'd1;
                        end else begin
                            tick_count = tick_count + 8'd1;
                        end
                    end
                end
                default: ;
            endcase
            r.levels = channel_levels();
            expected_resp.push_back(r);
        endfunction

        function void check_response(logic [31:0] m);
            pwm_resp_t e;
            if (expected_resp.size() == 0) begin
                errors++;
                $display("%0t: unexpected response %h", $time, m);
                return;
            end
            e = expected_resp.pop_front();
            if (m[7:0] !== e.read_data) begin
                errors++;
                $display("%0t: read_data expected %h actual %h", $time, e.read_data, m[7:0]);
            end
            if (m[23:8] !== e.levels) begin
                errors++;
                $display("%0t: pwm_levels expected %h actual %h", $time, e.levels, m[23:8]);
            end
            if (m[24] !== e.err) begin
                errors++;
                $display("%0t: access_error expected %b actual %b", $time, e.err, m[24]);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    int stall_pct  = 0;
    int idle_pct   = 0;
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    pwm_scoreboard sb = new();

    sixteen_channel_pwm_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata);
    end

    task automatic send_req(logic [1:0] c, logic [7:0] a, logic [7:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, a};
        s_tuser  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(c, a, d);
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.cfg_write(idx, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.expected_resp.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_req(CMD_READ, MODE_ADDR, 8'h00);
        send_req(CMD_READ, PRESCALE_ADDR, 8'h00);
        send_req(CMD_WRITE, PRESCALE_ADDR, 8'h00);
        send_req(CMD_READ, PRESCALE_ADDR, 8'h00);
        // Channel 0 wraps: on at 0xFFF, off at 2.
        send_req(CMD_WRITE, 8'h06, 8'hFF);
        send_req(CMD_WRITE, 8'h07, 8'hFF);
        send_req(CMD_READ, 8'h07, 8'h00);
        send_req(CMD_WRITE, 8'h08, 8'h02);
        send_req(CMD_WRITE, 8'h09, 8'h00);
        send_req(CMD_WRITE, 8'h42, 8'h00);
        send_req(CMD_WRITE, 8'h44, 8'h01);
        send_req(CMD_WRITE, 8'h45, 8'hF0);
        send_req(CMD_READ, 8'h45, 8'h00);
        send_req(CMD_READ, 8'h05, 8'h00);
        send_req(CMD_READ, 8'h46, 8'h00);
        send_req(CMD_WRITE, 8'hFF, 8'hAA);
        send_req(CMD_TICK, 8'h00, 8'h00);
        send_req(2'd3, 8'hFF, 8'hFF);
        send_req(CMD_WRITE, MODE_ADDR, 8'hEF);
        send_req(CMD_READ, MODE_ADDR, 8'h00);
        send_req(CMD_WRITE, PRESCALE_ADDR, 8'hFF);
        send_req(CMD_READ, PRESCALE_ADDR, 8'h00);
        repeat (9) send_req(CMD_TICK, 8'h00, 8'h00);
        send_req(CMD_WRITE, MODE_ADDR, 8'h10);
    endtask

    task automatic send_random_req();
        int         pick;
        int         sel;
        logic [1:0] c;
        logic [7:0] a;
        logic [7:0] d;
        pick = $urandom_range(99);
        c    = CMD_READ;
        a    = 8'($urandom_range(255));
        d    = 8'($urandom_range(255));
        if (pick < 40) begin
            c = CMD_TICK;
        end else if (pick < 65) begin
            // Place window edges close to the running count so levels change.
            c   = CMD_WRITE;
            sel = $urandom_range(3);
            a   = 8'(BASE_ADDR + 4 * $urandom_range(15) + sel);
            if ($urandom_range(3) != 0) begin
                if (sel % 2 == 1) begin
                    d = {4'($urandom_range(15)), sb.period[11:8]};
                end else begin
                    d = 8'(sb.period[7:0] + $urandom_range(50) - 10);
                end
            end
        end else if (pick < 78) begin
            a = 8'(BASE_ADDR + $urandom_range(63));
        end else if (pick < 84) begin
            c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            a = MODE_ADDR;
            d[SLEEP_BIT] = ($urandom_range(4) == 0);
        end else if (pick < 89) begin
            c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            a = PRESCALE_ADDR;
            if ($urandom_range(3) != 0) d = 8'($urandom_range(6));
        end else if (pick < 96) begin
            c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            case ($urandom_range(2))
                0: a = 8'($urandom_range(5, 1));
                1: a = 8'($urandom_range(8'hFD, 8'h46));
                default: a = 8'hFF;
            endcase
        end else begin
            c = 2'($urandom_range(3));
        end
        send_req(c, a, d);
    endtask

    task automatic run_phase(int idle, int stall, logic [7:0] psc, logic slp, int n_items,
                             bit hold_mid, bit pause_mid);
        cfg_write(CFG_PRESCALE, psc);
        cfg_write(CFG_SLEEP, {7'd0, slp});
        idle_pct   = idle;
        stall_pct <= stall;
        for (int i = 0; i < n_items; i++) begin
            if (hold_mid && i == n_items / 2) hold_token <= hold_token + 1;
            if (pause_mid && i == n_items / 3) begin
                s_tvalid <= 1'b0;
                while (sb.expected_resp.size() != 0) @(posedge aclk);
            end
            send_random_req();
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        drain();
        run_phase(0, 0, MIN_PRESCALE, 1'b0, 130, 1'b1, 1'b0);
        run_phase(55, 0, 8'd255, 1'b0, 120, 1'b0, 1'b1);
        run_phase(0, 55, 8'd0, 1'b0, 120, 1'b0, 1'b0);
        run_phase(30, 30, 8'($urandom_range(20, 3)), 1'b1, 130, 1'b1, 1'b1);
        if (sb.expected_resp.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.expected_resp.size());
        end
        if (sb.errors == 0 && sb.expected_resp.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
